/* rtl/tfm_pkg.sv */
// ---------------------------------------------------------------------------
// Topic filter match package
// Shared constants, character codes and types for the topic filter matcher.
// ---------------------------------------------------------------------------
package tfm_pkg;

  // Depth of the filter store in bytes.
  localparam int unsigned FILTER_DEPTH = 64;
  localparam int unsigned ADDR_W       = $clog2(FILTER_DEPTH);
  // Wide enough to hold FILTER_DEPTH itself (lengths, counts, positions).
  localparam int unsigned CNT_W        = $clog2(FILTER_DEPTH + 1);
  // Positions plus a small look-ahead offset.
  localparam int unsigned POS_W        = CNT_W + 2;

  // Characters with a special meaning in filters and topics.
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  // Operation codes carried in tuser.
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_TOPIC  = 1'b1;

  // One stored filter token: a literal byte, or a run of cnt plus signs.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [7:0]       chr;
  } token_t;

  // Write request into the token store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    token_t            data;
  } tok_wr_t;

  // Summary of the loaded filter, as seen by the topic matcher.
  typedef struct packed {
    logic [CNT_W-1:0] ntok;
    logic             ends_slash_hash;
    logic             overflow;
    token_t           tok0_next;
  } filter_info_t;

  // One result item.
  typedef struct packed {
    logic matched;
    logic overflow;
  } result_t;

endpackage

/* rtl/tfm_token_ram.sv */
// ---------------------------------------------------------------------------
// Token store
// Filter token memory with one write port and two registered read ports.
// A read of the address being written returns the new data.
// ---------------------------------------------------------------------------
module tfm_token_ram
  import tfm_pkg::*;
(
  input  logic              clk_i,
  input  tok_wr_t           wr_i,
  input  logic [ADDR_W-1:0] rd_addr_a_i,
  input  logic [ADDR_W-1:0] rd_addr_b_i,
  output token_t            rd_data_a_o,
  output token_t            rd_data_b_o
);

  token_t mem_q [FILTER_DEPTH];
  token_t rd_data_a_q;
  token_t rd_data_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read ports with write-first bypass.
  always_ff @(posedge clk_i) begin
    if (wr_i.we && (wr_i.addr == rd_addr_a_i)) begin
      rd_data_a_q <= wr_i.data;
    end else begin
      rd_data_a_q <= mem_q[rd_addr_a_i];
    end
    if (wr_i.we && (wr_i.addr == rd_addr_b_i)) begin
      rd_data_b_q <= wr_i.data;
    end else begin
      rd_data_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_data_a_q;
  assign rd_data_b_o = rd_data_b_q;

endmodule

/* rtl/tfm_filter_loader.sv */
// ---------------------------------------------------------------------------
// Filter loader
// Turns incoming filter bytes into tokens, merging runs of plus signs, and
// keeps the filter length, token count, overflow flag and tail flags.
// ---------------------------------------------------------------------------
module tfm_filter_loader
  import tfm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output tok_wr_t      wr_o,
  output filter_info_t info_o
);

  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] ntok_q, ntok_d;
  logic [CNT_W-1:0] last_cnt_q, last_cnt_d;
  logic             ovf_q, ovf_d;
  logic             closed_q, closed_d;
  logic             last_plus_q, last_plus_d;
  logic             last_slash_q, last_slash_d;
  logic             last_hash_q, last_hash_d;
  logic             second_slash_q, second_slash_d;
  token_t           tok0_q, tok0_d;

  logic [CNT_W-1:0] len_base;
  logic [CNT_W-1:0] ntok_base;
  logic             ovf_base;
  logic             last_plus_base;
  logic             last_slash_base;

  // A byte after a completed filter starts a new one.
  always_comb begin
    len_base        = closed_q ? '0 : len_q;
    ntok_base       = closed_q ? '0 : ntok_q;
    ovf_base        = closed_q ? 1'b0 : ovf_q;
    last_plus_base  = closed_q ? 1'b0 : last_plus_q;
    last_slash_base = closed_q ? 1'b0 : last_slash_q;
  end

  // Append the byte as a new token or extend the trailing plus run.
  always_comb begin
    len_d          = len_q;
    ntok_d         = ntok_q;
    last_cnt_d     = last_cnt_q;
    ovf_d          = ovf_q;
    closed_d       = closed_q;
    last_plus_d    = last_plus_q;
    last_slash_d   = last_slash_q;
    last_hash_d    = last_hash_q;
    second_slash_d = second_slash_q;
    wr_o           = '0;
    if (load_i) begin
      closed_d       = last_i;
      len_d          = len_base;
      ntok_d         = ntok_base;
      ovf_d          = ovf_base;
      last_plus_d    = last_plus_base;
      last_slash_d   = last_slash_base;
      if (len_base < CNT_W'(FILTER_DEPTH)) begin
        len_d = len_base + 1'b1;
        if ((byte_i == CH_PLUS) && last_plus_base) begin
          last_cnt_d    = last_cnt_q + 1'b1;
          wr_o.we       = 1'b1;
          wr_o.addr     = ADDR_W'(ntok_base - 1'b1);
          wr_o.data.chr = CH_PLUS;
          wr_o.data.cnt = last_cnt_d;
        end else begin
          ntok_d         = ntok_base + 1'b1;
          last_cnt_d     = CNT_W'(1);
          second_slash_d = last_slash_base;
          last_plus_d    = (byte_i == CH_PLUS);
          last_slash_d   = (byte_i == CH_SLASH);
          last_hash_d    = (byte_i == CH_HASH);
          wr_o.we        = 1'b1;
          wr_o.addr      = ADDR_W'(ntok_base);
          wr_o.data.chr  = byte_i;
          wr_o.data.cnt  = CNT_W'(1);
        end
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // Copy of the first token for the topic start and the dollar rule.
  always_comb begin
    tok0_d = tok0_q;
    if (wr_o.we && (wr_o.addr == '0)) begin
      tok0_d = wr_o.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q          <= '0;
      ntok_q         <= '0;
      last_cnt_q     <= '0;
      ovf_q          <= 1'b0;
      closed_q       <= 1'b1;
      last_plus_q    <= 1'b0;
      last_slash_q   <= 1'b0;
      last_hash_q    <= 1'b0;
      second_slash_q <= 1'b0;
    end else begin
      len_q          <= len_d;
      ntok_q         <= ntok_d;
      last_cnt_q     <= last_cnt_d;
      ovf_q          <= ovf_d;
      closed_q       <= closed_d;
      last_plus_q    <= last_plus_d;
      last_slash_q   <= last_slash_d;
      last_hash_q    <= last_hash_d;
      second_slash_q <= second_slash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok0_q <= tok0_d;
  end

  // Filter summary; the tail flag marks a filter ending in a slash followed by a hash.
  always_comb begin
    info_o.ntok            = ntok_q;
    info_o.ends_slash_hash = (ntok_q >= CNT_W'(2)) && second_slash_q && last_hash_q;
    info_o.overflow        = ovf_q;
    info_o.tok0_next       = tok0_d;
  end

endmodule

/* rtl/tfm_topic_matcher.sv */
// ---------------------------------------------------------------------------
// Topic matcher
// Walks the filter tokens one topic byte per cycle while topic_i is high,
// using a three-token window, and decides the match on the last topic byte.
// ---------------------------------------------------------------------------
module tfm_topic_matcher
  import tfm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              topic_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  filter_info_t      info_i,
  input  token_t            w1_i,
  input  token_t            w2_i,
  output logic [ADDR_W-1:0] rd_addr_a_o,
  output logic [ADDR_W-1:0] rd_addr_b_o,
  output logic              res_valid_o,
  output result_t           res_o
);

  logic [CNT_W-1:0] tpos_q, tpos_d;
  logic [CNT_W-1:0] sub_q, sub_d;
  logic             skip_q, skip_d;
  logic             mism_q, mism_d;
  logic             rest_q, rest_d;
  logic             start_q, start_d;
  token_t           w0_q, w0_d;

  logic [1:0]       adv;
  logic [CNT_W-1:0] sub_n;
  logic             skip_n, mism_n, rest_n;
  logic             dollar_fail;
  logic [POS_W-1:0] t_ext, ntok_ext, newt;
  logic             t0_in, t1_in;
  token_t           sel;
  logic             tail_ok;
  logic [POS_W-1:0] addr_a, addr_b;

  assign t_ext    = POS_W'(tpos_q);
  assign ntok_ext = POS_W'(info_i.ntok);
  assign t0_in    = (t_ext < ntok_ext);
  assign t1_in    = ((t_ext + 1'b1) < ntok_ext);

  // A dollar topic does not match a filter that opens with a wildcard.
  assign dollar_fail = start_q && (byte_i == CH_DOLLAR) && (info_i.ntok != '0) &&
                       ((w0_q.chr == CH_PLUS) || (w0_q.chr == CH_HASH));

  // Advance over the filter for one topic byte.
  always_comb begin
    adv    = 2'd0;
    sub_n  = sub_q;
    skip_n = skip_q;
    mism_n = mism_q;
    rest_n = rest_q;
    if (!mism_q && !rest_q) begin
      if (dollar_fail) begin
        mism_n = 1'b1;
      end else if (!skip_q || (byte_i == CH_SLASH)) begin
        skip_n = 1'b0;
        if (!t0_in) begin
          mism_n = 1'b1;
        end else if (w0_q.chr == CH_HASH) begin
          rest_n = 1'b1;
        end else if (w0_q.chr == CH_PLUS) begin
          if (byte_i != CH_SLASH) begin
            // The plus swallows this level; step one plus of the run.
            skip_n = 1'b1;
            if ((POS_W'(sub_q) + 1'b1) < POS_W'(w0_q.cnt)) begin
              sub_n = sub_q + 1'b1;
            end else begin
              adv   = 2'd1;
              sub_n = '0;
            end
          end else if (!t1_in) begin
            mism_n = 1'b1;
          end else if (w1_i.chr == CH_HASH) begin
            rest_n = 1'b1;
          end else if (w1_i.chr == CH_SLASH) begin
            // Empty level under the plus run, then the separator.
            adv   = 2'd2;
            sub_n = '0;
          end else begin
            mism_n = 1'b1;
          end
        end else if (w0_q.chr == byte_i) begin
          adv = 2'd1;
        end else begin
          mism_n = 1'b1;
        end
      end
    end
  end

  // Token at the new position.
  always_comb begin
    newt = t_ext + POS_W'(adv);
    case (adv)
      2'd0:    sel = w0_q;
      2'd1:    sel = w1_i;
      default: sel = w2_i;
    endcase
  end

  // Can the rest of the filter match an empty topic tail?
  always_comb begin
    tail_ok = 1'b0;
    if (newt >= ntok_ext) begin
      tail_ok = 1'b1;
    end else if (((newt + POS_W'(2)) == ntok_ext) && info_i.ends_slash_hash) begin
      tail_ok = 1'b1;
    end else if (!skip_n && (sel.chr == CH_HASH)) begin
      tail_ok = 1'b1;
    end else if (!skip_n && (sel.chr == CH_PLUS) &&
                 ((POS_W'(sub_n) + 1'b1) == POS_W'(sel.cnt)) &&
                 (((newt + 1'b1) >= ntok_ext) ||
                  (((newt + POS_W'(3)) == ntok_ext) && info_i.ends_slash_hash))) begin
      tail_ok = 1'b1;
    end
  end

  assign res_valid_o  = topic_i && last_i;
  assign res_o.matched  = !info_i.overflow && !mism_n && (rest_n || tail_ok);
  assign res_o.overflow = info_i.overflow;

  // Next walk state; a filter byte or the end of a topic restarts the walk.
  always_comb begin
    tpos_d  = tpos_q;
    sub_d   = sub_q;
    skip_d  = skip_q;
    mism_d  = mism_q;
    rest_d  = rest_q;
    start_d = start_q;
    w0_d    = w0_q;
    if (load_i || (topic_i && last_i)) begin
      tpos_d  = '0;
      sub_d   = '0;
      skip_d  = 1'b0;
      mism_d  = 1'b0;
      rest_d  = 1'b0;
      start_d = 1'b1;
      w0_d    = info_i.tok0_next;
    end else if (topic_i) begin
      tpos_d  = CNT_W'(newt);
      sub_d   = sub_n;
      skip_d  = skip_n;
      mism_d  = mism_n;
      rest_d  = rest_n;
      start_d = 1'b0;
      w0_d    = sel;
    end
  end

  // Fetch the two tokens after the new position.
  assign addr_a      = POS_W'(tpos_d) + POS_W'(1);
  assign addr_b      = POS_W'(tpos_d) + POS_W'(2);
  assign rd_addr_a_o = addr_a[ADDR_W-1:0];
  assign rd_addr_b_o = addr_b[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpos_q  <= '0;
      sub_q   <= '0;
      skip_q  <= 1'b0;
      mism_q  <= 1'b0;
      rest_q  <= 1'b0;
      start_q <= 1'b1;
    end else begin
      tpos_q  <= tpos_d;
      sub_q   <= sub_d;
      skip_q  <= skip_d;
      mism_q  <= mism_d;
      rest_q  <= rest_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w0_q <= w0_d;
  end

endmodule

/* rtl/topic_filter_wildcard_match_unit.sv */
// ---------------------------------------------------------------------------
// Topic filter wildcard match unit
// Matches streamed topic names against a loaded topic filter with '+' and
// '#' wildcards and the dollar-topic rule.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_axis: one byte per transaction. tuser selects the kind:
//   0 loads a filter byte, 1 presents a topic byte. tlast marks the final
//   byte of a filter or of a topic. A filter byte after a completed filter
//   starts a new filter; any filter byte abandons a partly received topic.
//   Output channel m_axis: one transaction per topic, issued for the topic
//   byte that carries tlast, with the match bit and the overflow flag.
//   Filters longer than FILTER_DEPTH bytes raise the overflow flag and
//   never match.
//   Throughput: one byte per cycle on filter and topic bytes unless m_axis stalls.
//   A result passes the input register, then the output register, once its
//   last topic byte is taken. The per-byte step is one token compare from a
//   three-token window fed by two read ports of the token store.
//   Reset: the filter is empty and no topic is in progress; all topics give
//   no match until a filter is loaded. No clearing pass is needed.
//   Back-pressure: when m_axis_tready is low with a result waiting, one
//   more byte is held in the input register and s_axis_tready drops.
// ---------------------------------------------------------------------------
module topic_filter_wildcard_match_unit
  import tfm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] op
  input  logic       s_axis_tlast,   // last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] matched, [1] filter_overflow, [7:2] zero
);

  logic         in_valid_q;
  logic         in_op_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         out_valid_q;
  result_t      out_res_q;
  logic         proc;
  logic         load;
  logic         topic;
  tok_wr_t      wr;
  filter_info_t info;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  token_t       w1, w2;
  logic         res_valid;
  result_t      res;

  // The held byte is processed when the output register can take a result.
  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign load          = proc && (in_op_q == OP_FILTER);
  assign topic         = proc && (in_op_q == OP_TOPIC);
  assign s_axis_tready = !in_valid_q || proc;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  tfm_filter_loader u_loader (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .wr_o   (wr),
    .info_o (info)
  );

  tfm_token_ram u_ram (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (w1),
    .rd_data_b_o (w2)
  );

  tfm_topic_matcher u_matcher (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .topic_i     (topic),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .info_i      (info),
    .w1_i        (w1),
    .w2_i        (w2),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_res_q.overflow, out_res_q.matched};

endmodule

/* rtl/tfm_checker.sv */
// ---------------------------------------------------------------------------
// Topic filter match port checker
// Checks port behaviour of the match unit over time; bound to the top level.
// ---------------------------------------------------------------------------
module tfm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tuser,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A stalled result transaction keeps its valid and its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result transaction changed while stalled");

  // A new result follows the last byte of a topic, through the input and output registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast, 2))
    else $error("result without a completed topic");

  // The input side only stalls behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while the output is free");

  // An overflowed filter never reports a match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
    else $error("match reported with filter overflow");

endmodule

bind topic_filter_wildcard_match_unit tfm_checker u_checker (.*);

/* test/topic_filter_match_checker.sv */
// ---------------------------------------------------------------------------
// Topic filter match checker
// Watches both stream channels of the topic filter matcher. It keeps its
// own model of the filter store and the topic walk, works out the result
// owed for every closing topic byte, and compares each output transaction
// with the oldest result still owed.
// ---------------------------------------------------------------------------
module topic_filter_match_checker
  import tfm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic              s_axis_tuser,   // [0] op
  input  logic              s_axis_tlast,   // last
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [7:0]        m_axis_tdata,   // [0] matched, [1] filter_overflow, [7:2] zero
  output int unsigned       mismatch_total_o,
  output int unsigned       results_owed_o
);

  // Model of the loaded filter.
  logic [7:0]       flt_bytes [FILTER_DEPTH];
  logic [CNT_W-1:0] flt_count;
  logic             flt_overflow;
  logic             flt_done;

  // Model of the topic walk through the filter.
  logic [CNT_W-1:0] cursor;
  logic             in_plus;
  logic             failed;
  logic             hash_hit;
  logic             first_byte;

  result_t          owed_q [$];
  int unsigned      mismatches;

  // Only entries below the current length are ever looked at.
  function automatic logic [7:0] flt_at(int unsigned i);
    return (i < flt_count) ? flt_bytes[i[ADDR_W-1:0]] : 8'h00;
  endfunction

  function automatic void restart_topic();
    cursor     = '0;
    in_plus    = 1'b0;
    failed     = 1'b0;
    hash_hit   = 1'b0;
    first_byte = 1'b1;
  endfunction

  function automatic void take_filter_byte(logic [7:0] b, logic lst);
    // A filter byte after a closed filter begins a fresh one.
    if (flt_done) begin
      flt_count    = '0;
      flt_overflow = 1'b0;
      flt_done     = 1'b0;
    end
    if (flt_count < FILTER_DEPTH) begin
      flt_bytes[flt_count[ADDR_W-1:0]] = b;
      flt_count++;
    end else begin
      flt_overflow = 1'b1;
    end
    if (lst) flt_done = 1'b1;
    restart_topic();
  endfunction

  // Advance the walk by one topic byte.
  function automatic void eat_topic_byte(logic [7:0] b);
    logic [7:0] f;
    if (failed || hash_hit) return;
    if (first_byte) begin
      first_byte = 1'b0;
      // A dollar topic never matches a filter that opens with a wildcard.
      if (b == CH_DOLLAR && flt_count > 0 &&
          (flt_at(0) == CH_PLUS || flt_at(0) == CH_HASH)) begin
        failed = 1'b1;
        return;
      end
    end
    for (int g = 0; g <= FILTER_DEPTH + 1; g++) begin
      // Inside a plus level every byte up to the next slash is swallowed.
      if (in_plus) begin
        if (b != CH_SLASH) return;
        in_plus = 1'b0;
      end
      if (cursor >= flt_count) begin
        failed = 1'b1;
        return;
      end
      f = flt_at(cursor);
      if (f == CH_HASH) begin
        hash_hit = 1'b1;
        return;
      end
      if (f == CH_PLUS) begin
        in_plus = 1'b1;
        cursor++;
        continue;
      end
      if (f == b) cursor++;
      else failed = 1'b1;
      return;
    end
  endfunction

  // Whether the unread part of the filter accepts an empty rest of topic.
  function automatic logic tail_matches();
    int unsigned p;
    p = cursor;
    if (!in_plus && p < flt_count) begin
      if (flt_at(p) == CH_HASH) return 1'b1;
      if (flt_at(p) == CH_PLUS) p++;
    end
    if (p >= flt_count) return 1'b1;
    return (p + 2 == flt_count) && (flt_at(p) == CH_SLASH) &&
           (flt_at(p + 1) == CH_HASH);
  endfunction

  // Follow every transaction on both channels.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      flt_count    = '0;
      flt_overflow = 1'b0;
      flt_done     = 1'b1;
      restart_topic();
      owed_q.delete();
      mismatches   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_FILTER) begin
          take_filter_byte(s_axis_tdata, s_axis_tlast);
        end else begin
          eat_topic_byte(s_axis_tdata);
          if (s_axis_tlast) begin
            want.matched  = !flt_overflow && !failed && (hash_hit || tail_matches());
            want.overflow = flt_overflow;
            owed_q.push_back(want);
            restart_topic();
          end
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_q.size() == 0) begin
          $error("result transaction with none owed: tdata %02h", m_axis_tdata);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (m_axis_tdata[0] !== want.matched) begin
            $error("matched: expected %0b, actual %0b", want.matched, m_axis_tdata[0]);
            mismatches++;
          end
          if (m_axis_tdata[1] !== want.overflow) begin
            $error("filter_overflow: expected %0b, actual %0b",
                   want.overflow, m_axis_tdata[1]);
            mismatches++;
          end
          if (m_axis_tdata[7:2] !== 6'b0) begin
            $error("tdata padding: expected %02h, actual %02h",
                   6'b0, m_axis_tdata[7:2]);
            mismatches++;
          end
        end
      end
    end
    mismatch_total_o <= mismatches;
    results_owed_o   <= owed_q.size();
  end

endmodule

/* test/topic_filter_wildcard_match_unit_test.sv */
// ---------------------------------------------------------------------------
// Topic filter wildcard match unit testbench
// Loads topic filters and streams topics through the matcher: a directed
// opening over the wildcard and dollar rules, then randomised filters with
// topics mostly derived from them, mixed with noise and broken sequences.
// Both channels idle at random; the receiver also holds off for long
// stretches so the block back-pressures its input.
// ---------------------------------------------------------------------------
module topic_filter_wildcard_match_unit_test;
  import tfm_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = OP_FILTER;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  int unsigned mismatch_total;
  int unsigned results_owed;
  int unsigned items_sent = 0;
  bit          steady     = 1'b0;

  topic_filter_wildcard_match_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  topic_filter_match_checker match_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_total_o (mismatch_total),
    .results_owed_o   (results_owed)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop, many times the length of a correct run.
  initial begin
    #8000000;
    $display("topic_filter_wildcard_match_unit_test: done, errors");
    $finish;
  end

  // Result receiver, with a long hold-off at result counts 25 and 350.
  initial begin : receiver
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 12);
      if (taken == 25 || taken == 350) gap = 300;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  // Offer one byte and wait for its transaction.
  task automatic put_item(input logic op, input logic [7:0] b, input logic lst);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_bytes(input logic op, input logic [7:0] q[$], input logic close);
    for (int i = 0; i < q.size(); i++) put_item(op, q[i], close && (i == q.size() - 1));
  endtask

  // Mostly a small alphabet so that topics often agree with filters.
  function automatic logic [7:0] level_char();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  // A filter of one to four levels with plus, hash and empty levels.
  task automatic make_filter(ref logic [7:0] flt[$]);
    int unsigned levels;
    int unsigned r;
    flt.delete();
    levels = $urandom_range(1, 4);
    for (int l = 0; l < levels; l++) begin
      if (l > 0) flt.push_back(CH_SLASH);
      r = $urandom_range(0, 99);
      if (l == levels - 1 && r < 15) begin
        flt.push_back(CH_HASH);
      end else if (r < 35) begin
        flt.push_back(CH_PLUS);
      end else if (r >= 42) begin
        repeat ($urandom_range(1, 3)) flt.push_back(level_char());
        // Now and then a wildcard sits inside a level.
        if (r < 48) flt.push_back($urandom_range(0, 1) ? CH_PLUS : CH_HASH);
      end
    end
    if (flt.size() == 0) flt.push_back(level_char());
  endtask

  // A topic built to fit the filter, then sometimes spoiled.
  task automatic make_topic(input logic [7:0] flt[$], ref logic [7:0] tp[$]);
    bit          stop;
    int unsigned r;
    tp.delete();
    stop = 1'b0;
    for (int i = 0; i < flt.size() && !stop; i++) begin
      if (flt[i] == CH_PLUS) begin
        repeat ($urandom_range(0, 3)) tp.push_back(level_char());
      end else if (flt[i] == CH_HASH) begin
        case ($urandom_range(0, 2))
          0: ;
          // Parent level: drop the slash before the hash.
          1: if (tp.size() > 0 && tp[tp.size() - 1] == CH_SLASH) void'(tp.pop_back());
          default: repeat ($urandom_range(1, 4))
                     tp.push_back(($urandom_range(0, 2) == 0) ? CH_SLASH : level_char());
        endcase
        stop = 1'b1;
      end else begin
        tp.push_back(flt[i]);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 10 && tp.size() > 0) begin
      tp[$urandom_range(0, tp.size() - 1)] = level_char();
    end else if (r < 16) begin
      tp.push_back(level_char());
    end else if (r < 22 && tp.size() > 0) begin
      void'(tp.pop_back());
    end else if (r < 30) begin
      if (tp.size() > 0) tp[0] = CH_DOLLAR;
      else tp.push_back(CH_DOLLAR);
    end
    if (tp.size() == 0) tp.push_back(level_char());
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    logic [7:0]  flt [$];
    logic [7:0]  tp [$];
    logic [7:0]  part [$];
    int unsigned round;
    int unsigned r;
    int unsigned k;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty filter straight after reset.
    put_item(OP_TOPIC, "a", 1'b1);
    // Lone hash: a dollar topic is refused, anything else matches.
    put_item(OP_FILTER, CH_HASH, 1'b1);
    put_item(OP_TOPIC, CH_DOLLAR, 1'b1);
    put_item(OP_TOPIC, 8'h00, 1'b0);
    put_item(OP_TOPIC, 8'hFF, 1'b1);
    // Hash also matches its parent level.
    put_item(OP_FILTER, "a", 1'b0);
    put_item(OP_FILTER, CH_SLASH, 1'b0);
    put_item(OP_FILTER, CH_HASH, 1'b1);
    put_item(OP_TOPIC, "a", 1'b1);
    // Plus in the middle of a level.
    put_item(OP_FILTER, "a", 1'b0);
    put_item(OP_FILTER, CH_PLUS, 1'b0);
    put_item(OP_FILTER, "b", 1'b1);
    put_item(OP_TOPIC, "a", 1'b0);
    put_item(OP_TOPIC, "x", 1'b1);
    // A filter byte abandons a topic in flight.
    put_item(OP_TOPIC, "a", 1'b0);
    put_item(OP_FILTER, "z", 1'b1);
    put_item(OP_TOPIC, "z", 1'b1);
    // Topic against a filter still being loaded, then the filter grows.
    put_item(OP_FILTER, "q", 1'b0);
    put_item(OP_TOPIC, "q", 1'b1);
    put_item(OP_FILTER, CH_PLUS, 1'b1);
    put_item(OP_TOPIC, "q", 1'b0);
    put_item(OP_TOPIC, "r", 1'b1);
    // Topic with more levels than the filter.
    put_item(OP_FILTER, CH_PLUS, 1'b1);
    put_item(OP_TOPIC, "a", 1'b0);
    put_item(OP_TOPIC, CH_SLASH, 1'b0);
    put_item(OP_TOPIC, "b", 1'b1);

    round = 0;
    while (items_sent < 830) begin
      steady = ($urandom_range(0, 5) == 0);
      if (round % 12 == 11) begin
        // Filter longer than the store.
        flt.delete();
        repeat (FILTER_DEPTH + $urandom_range(1, 3)) flt.push_back(level_char());
        send_bytes(OP_FILTER, flt, 1'b1);
        repeat (2) begin
          make_topic(flt, tp);
          send_bytes(OP_TOPIC, tp, 1'b1);
        end
      end else if (round % 12 == 5) begin
        // Filter that fills the store exactly, ending in a hash.
        flt.delete();
        repeat (FILTER_DEPTH - 1) flt.push_back(level_char());
        flt.push_back(CH_HASH);
        send_bytes(OP_FILTER, flt, 1'b1);
        make_topic(flt, tp);
        send_bytes(OP_TOPIC, tp, 1'b1);
      end else begin
        r = $urandom_range(0, 99);
        make_filter(flt);
        if (r < 75) begin
          send_bytes(OP_FILTER, flt, 1'b1);
          repeat ($urandom_range(1, 5)) begin
            make_topic(flt, tp);
            send_bytes(OP_TOPIC, tp, 1'b1);
          end
        end else if (r < 85) begin
          // Noise: any kind, any byte, any end mark.
          repeat ($urandom_range(3, 15)) begin
            put_item($urandom_range(0, 1) ? OP_TOPIC : OP_FILTER,
                     ($urandom_range(0, 1) == 0) ? level_char() : 8'($urandom_range(0, 255)),
                     $urandom_range(0, 3) == 0);
          end
        end else if (r < 92) begin
          // A topic cut short by a new filter.
          make_topic(flt, tp);
          send_bytes(OP_TOPIC, tp, 1'b0);
          send_bytes(OP_FILTER, flt, 1'b1);
          make_topic(flt, tp);
          send_bytes(OP_TOPIC, tp, 1'b1);
        end else begin
          // Topics matched against a filter loaded in two parts.
          k = $urandom_range(1, flt.size());
          part.delete();
          for (int i = 0; i < k; i++) part.push_back(flt[i]);
          send_bytes(OP_FILTER, part, 1'b0);
          make_topic(part, tp);
          send_bytes(OP_TOPIC, tp, 1'b1);
          part.delete();
          for (int i = k; i < flt.size(); i++) part.push_back(flt[i]);
          if (part.size() == 0) begin
            part.push_back(CH_HASH);
            flt.push_back(CH_HASH);
          end
          send_bytes(OP_FILTER, part, 1'b1);
          make_topic(flt, tp);
          send_bytes(OP_TOPIC, tp, 1'b1);
        end
      end
      round++;
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    // Drain the owed results, then allow for the pipeline.
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("topic_filter_wildcard_match_unit_test: done, clean");
    end else begin
      $display("topic_filter_wildcard_match_unit_test: done, errors");
    end
    $finish;
  end

endmodule
